// ===== design/akat_pkg.sv =====
// ----------------------------------------------------------------------------
// akat_pkg: shared types and constants of the analog key actuation tracker
// Register indexes, threshold mode codes, item, state and result layouts.
// ----------------------------------------------------------------------------
package akat_pkg;

   // Default parameter values
   localparam int KEY_COUNT_DEF   = 128;
   localparam int SAMPLE_BITS_DEF = 12;

   // Field widths
   localparam int KEY_W   = 7;
   localparam int SMP_W   = 12;
   localparam int CNT_W   = 32;
   localparam int MODE_W  = 2;
   localparam int CSR_A_W = 3;

   // Stream widths, whole bytes
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 56;

   // Queue depths and the credit counter that covers the result path
   localparam int ITEM_DEPTH = 4;
   localparam int RSP_DEPTH  = 4;
   localparam int CRED_W     = $clog2(RSP_DEPTH + 1);

   // Register indexes
   localparam logic [CSR_A_W-1:0] REG_DEADZONE     = 3'd0;
   localparam logic [CSR_A_W-1:0] REG_PRESS_MODE   = 3'd1;
   localparam logic [CSR_A_W-1:0] REG_RELEASE_MODE = 3'd2;
   localparam logic [CSR_A_W-1:0] REG_PRESS_LVL    = 3'd3;
   localparam logic [CSR_A_W-1:0] REG_RELEASE_LVL  = 3'd4;
   localparam logic [CSR_A_W-1:0] REG_SEC_MODE     = 3'd5;
   localparam logic [CSR_A_W-1:0] REG_SEC_PRESS    = 3'd6;
   localparam logic [CSR_A_W-1:0] REG_SEC_RELEASE  = 3'd7;

   // Primary threshold modes
   localparam logic [MODE_W-1:0] MODE_EDGE    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_LEVEL   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_DYNAMIC = 2'd2;

   // Secondary action modes
   localparam logic [MODE_W-1:0] SEC_OFF    = 2'd0;
   localparam logic [MODE_W-1:0] SEC_FOLLOW = 2'd1;
   localparam logic [MODE_W-1:0] SEC_BELOW  = 2'd2;

   typedef struct packed {
      logic [SMP_W-1:0]  sec_release;
      logic [SMP_W-1:0]  sec_press;
      logic [MODE_W-1:0] sec_mode;
      logic [SMP_W-1:0]  release_lvl;
      logic [SMP_W-1:0]  press_lvl;
      logic [MODE_W-1:0] rel_mode;
      logic [MODE_W-1:0] press_mode;
      logic [SMP_W-1:0]  deadzone;
   } cfg_type;

   // Classified item between front and back
   typedef struct packed {
      logic [SMP_W-1:0] clamped;
      logic             at_dz;
      logic [SMP_W-1:0] sample;
      logic             key_ok;
      logic [KEY_W-1:0] key;
   } item_type;

   // Per-key state word held in memory
   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic [SMP_W-1:0] ext;
      logic             sec;
      logic             prim;
   } state_type;

   // Result word, last field in the low bits
   typedef struct packed {
      logic [CNT_W-1:0] press_total;
      logic [SMP_W-1:0] travel_extremum;
      logic             second_changed;
      logic             second_pressed;
      logic             primary_changed;
      logic             prim_state;
      logic [KEY_W-1:0] out_key_index;
   } result_type;

   // Back-end status seen by the top level
   typedef struct packed {
      logic              clearing;
      logic              issue;
      logic              result_push;
      logic [CRED_W-1:0] credit;
   } status_type;

endpackage

// ===== design/akat_ram.sv =====
// ----------------------------------------------------------------------------
// akat_ram: generic single-write, single-read memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module akat_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/akat_fifo.sv =====
// ----------------------------------------------------------------------------
// akat_fifo: short register queue
// Power-of-two depth, push when not full, pop when not empty.
// ----------------------------------------------------------------------------
module akat_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             full,
   output logic             empty
);

   localparam int PtrW = $clog2(DEPTH);
   localparam int CntW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CntW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + CntW'(do_push) - CntW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== design/akat_front.sv =====
// ----------------------------------------------------------------------------
// akat_front: sample intake and classification
// Range-check the key, mask the sample, compare against the deadzone and
// queue the classified item for the back end.
// ----------------------------------------------------------------------------
module akat_front
   import akat_pkg::*;
#(
   parameter int KEY_COUNT   = KEY_COUNT_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic                  accept_en,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  item_pop,
   output logic                  item_valid,
   output item_type              item
);

   localparam logic [SMP_W-1:0] SampleMask =
      (SAMPLE_BITS >= SMP_W) ? {SMP_W{1'b1}} : SMP_W'((1 << SAMPLE_BITS) - 1);

   logic             q_full, q_empty;
   item_type         cls;
   logic [SMP_W-1:0] smp;

   always_comb begin
      smp         = req_tdata[KEY_W +: SMP_W] & SampleMask;
      cls.key     = req_tdata[KEY_W-1:0];
      cls.key_ok  = (32'(cls.key) < 32'(KEY_COUNT));
      cls.sample  = smp;
      cls.at_dz   = (smp <= cfg.deadzone);
      // floor the sample at the deadzone for extremum tracking
      cls.clamped = (smp < cfg.deadzone) ? cfg.deadzone : smp;
   end

   assign req_tready = accept_en && !q_full;
   assign item_valid = !q_empty;

   akat_fifo #(
      .WIDTH($bits(item_type)),
      .DEPTH(ITEM_DEPTH)
   ) u_item_q (
      .clock    (clock),
      .reset    (reset),
      .push     (req_tvalid && req_tready),
      .push_data(cls),
      .pop      (item_pop),
      .pop_data (item),
      .full     (q_full),
      .empty    (q_empty)
   );

endmodule

// ===== design/akat_back.sv =====
// ----------------------------------------------------------------------------
// akat_back: per-key state update
// Read the key's state word, apply the press and release rules, write the
// word back and queue the result. Clears the state memory after reset.
// ----------------------------------------------------------------------------
module akat_back
   import akat_pkg::*;
#(
   parameter int KEY_COUNT = KEY_COUNT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic                  item_valid,
   input  item_type              item,
   output logic                  item_pop,
   output status_type            stat,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int AddrW   = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
   localparam int KeyWide = (AddrW > KEY_W) ? AddrW : KEY_W;
   localparam int StateW  = $bits(state_type);

   // clear sweep
   logic             clr_active_ff, clr_active_in;
   logic [AddrW-1:0] clr_addr_ff, clr_addr_in;

   // update stage
   logic             b_valid_ff, b_valid_in;
   item_type         b_item_ff, b_item_in;
   logic             fwd_hit_ff, fwd_hit_in;
   state_type        fwd_data_ff, fwd_data_in;
   logic [CRED_W-1:0] credit_ff, credit_in;

   logic             issue, rsp_pop, q_full, q_empty;
   logic [KeyWide-1:0] rd_key_w, wr_key_w;
   logic [AddrW-1:0] rd_addr, b_addr, wr_addr;
   logic             wr_en;
   state_type        wr_data;
   logic [StateW-1:0] ram_rd_data;

   state_type        cur, nxt;
   logic             press_hit, release_hit, sec_rel;
   logic             pchg, schg;
   logic [SMP_W-1:0] s;
   result_type       res;

   // issue only with room for the result downstream
   assign issue    = item_valid && !clr_active_ff && (credit_ff < CRED_W'(RSP_DEPTH));
   assign item_pop = issue;
   assign rsp_pop  = rsp_tvalid && rsp_tready;

   assign rd_key_w = KeyWide'(item.key);
   assign wr_key_w = KeyWide'(b_item_ff.key);
   assign rd_addr  = rd_key_w[AddrW-1:0];
   assign b_addr   = wr_key_w[AddrW-1:0];

   assign wr_en   = clr_active_ff || (b_valid_ff && b_item_ff.key_ok);
   assign wr_addr = clr_active_ff ? clr_addr_ff : b_addr;
   assign wr_data = clr_active_ff ? state_type'('0) : nxt;

   akat_ram #(
      .WIDTH(StateW),
      .DEPTH(KEY_COUNT)
   ) u_state_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(ram_rd_data)
   );

   // rules
   always_comb begin
      cur = fwd_hit_ff ? fwd_data_ff : state_type'(ram_rd_data);
      s   = b_item_ff.sample;

      press_hit = 1'b0;
      unique case (cfg.press_mode)
         MODE_EDGE:    press_hit = (cur.ext <= cfg.press_lvl) && (s > cfg.press_lvl);
         MODE_LEVEL:   press_hit = (s > cfg.press_lvl);
         MODE_DYNAMIC: press_hit = (s > cur.ext) && ((s - cur.ext) > cfg.press_lvl);
         default:      press_hit = 1'b0;
      endcase
      press_hit = press_hit && !b_item_ff.at_dz;

      release_hit = 1'b0;
      unique case (cfg.rel_mode)
         MODE_EDGE:    release_hit = (cur.ext >= cfg.release_lvl) &&
                                     (s < cfg.release_lvl);
         MODE_LEVEL:   release_hit = (s < cfg.release_lvl);
         MODE_DYNAMIC: release_hit = (s < cur.ext) &&
                                     ((cur.ext - s) > cfg.release_lvl);
         default:      release_hit = 1'b0;
      endcase
      release_hit = release_hit || b_item_ff.at_dz;

      nxt  = cur;
      pchg = 1'b0;
      if (cur.prim) begin
         if (release_hit) begin
            nxt.prim = 1'b0;
            pchg     = 1'b1;
            nxt.ext  = b_item_ff.clamped;
         end else if (b_item_ff.clamped > cur.ext) begin
            nxt.ext = b_item_ff.clamped;
         end
      end else begin
         if (press_hit) begin
            nxt.prim  = 1'b1;
            pchg      = 1'b1;
            nxt.ext   = b_item_ff.clamped;
            nxt.count = cur.count + 1'b1;
         end else if (b_item_ff.clamped < cur.ext) begin
            nxt.ext = b_item_ff.clamped;
         end
      end

      sec_rel = 1'b0;
      unique case (cfg.sec_mode)
         SEC_FOLLOW: sec_rel = !nxt.prim;
         SEC_BELOW:  sec_rel = (s < cfg.sec_release);
         default:    sec_rel = 1'b0;
      endcase
      sec_rel = sec_rel || b_item_ff.at_dz;

      schg = 1'b0;
      if (cfg.sec_mode != SEC_OFF) begin
         if (cur.sec) begin
            schg = sec_rel;
         end else begin
            schg = !b_item_ff.at_dz && (s > cfg.sec_press);
         end
      end
      nxt.sec = cur.sec ^ schg;

      res               = '0;
      res.out_key_index = b_item_ff.key;
      if (b_item_ff.key_ok) begin
         res.prim_state      = nxt.prim;
         res.primary_changed = pchg;
         res.second_pressed  = nxt.sec;
         res.second_changed  = schg;
         res.travel_extremum = nxt.ext;
         res.press_total     = nxt.count;
      end
   end

   always_comb begin
      clr_active_in = clr_active_ff && (clr_addr_ff != AddrW'(KEY_COUNT - 1));
      clr_addr_in   = clr_active_ff ? clr_addr_ff + 1'b1 : clr_addr_ff;
      b_valid_in    = issue;
      b_item_in     = issue ? item : b_item_ff;
      // same-key write in the cycle of the read: take the written word
      fwd_hit_in    = wr_en && (wr_addr == rd_addr);
      fwd_data_in   = wr_data;
      credit_in     = credit_ff + CRED_W'(issue) - CRED_W'(rsp_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
         b_valid_ff    <= 1'b0;
         credit_ff     <= '0;
      end else begin
         clr_active_ff <= clr_active_in;
         clr_addr_ff   <= clr_addr_in;
         b_valid_ff    <= b_valid_in;
         credit_ff     <= credit_in;
      end
   end

   always_ff @(posedge clock) begin
      b_item_ff   <= b_item_in;
      fwd_hit_ff  <= fwd_hit_in;
      fwd_data_ff <= fwd_data_in;
   end

   akat_fifo #(
      .WIDTH(RSP_DATA_W),
      .DEPTH(RSP_DEPTH)
   ) u_rsp_q (
      .clock    (clock),
      .reset    (reset),
      .push     (b_valid_ff),
      .push_data({1'b0, res}),
      .pop      (rsp_pop),
      .pop_data (rsp_tdata),
      .full     (q_full),
      .empty    (q_empty)
   );

   assign rsp_tvalid = !q_empty;

   always_comb begin
      stat.clearing    = clr_active_ff;
      stat.issue       = issue;
      stat.result_push = b_valid_ff && !q_full;
      stat.credit      = credit_ff;
   end

endmodule

// ===== design/analog_key_actuation_tracker_core.sv =====
// ----------------------------------------------------------------------------
// analog_key_actuation_tracker_core: rapid-trigger analog key tracker
// Per-key primary and secondary press state, travel extremum and press count.
// ----------------------------------------------------------------------------
//  channel  ports                      direction  contents
//  req      req_tvalid/tready/tdata    in         one sample for one key
//  rsp      rsp_tvalid/tready/tdata    out        key state after the sample
//  csr      csr_valid/ready/index/data in         threshold register writes
//
//  One transaction per cycle sustained in both directions while rsp is ready.
//  A sample passes through the item queue, then the registered read of the
//  state memory with the update and write-back, then the result queue.
//  The read-modify-write of the state memory stays exact by forwarding: a
//  same-key sample in the next cycle takes the just-written word.
//  After reset the state memory is swept to zero, one key a cycle, all keys;
//  req_tready stays low meanwhile, csr writes are taken throughout.
//  A stalled rsp holds results in a four-deep queue; the intake keeps going
//  until that queue and the four-deep item queue fill.
// ----------------------------------------------------------------------------
module analog_key_actuation_tracker_core
   import akat_pkg::*;
#(
   parameter int KEY_COUNT   = KEY_COUNT_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // req_tdata: key_index [6:0], sample [18:7], zero fill [23:19]
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // rsp_tdata: out_key_index [6:0], prim_state [7], primary_changed [8],
   // second_pressed [9], second_changed [10], travel_extremum [22:11],
   // press_total [54:23], zero fill [55]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_A_W-1:0]    csr_index,
   input  logic [SMP_W-1:0]      csr_data
);

   cfg_type    cfg_ff, cfg_in;
   status_type stat;
   item_type   item;
   logic       item_valid, item_pop;

   // Registers: always ready, hold until written
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_DEADZONE:     cfg_in.deadzone     = csr_data;
            REG_PRESS_MODE:   cfg_in.press_mode   = csr_data[MODE_W-1:0];
            REG_RELEASE_MODE: cfg_in.rel_mode     = csr_data[MODE_W-1:0];
            REG_PRESS_LVL:    cfg_in.press_lvl    = csr_data;
            REG_RELEASE_LVL:  cfg_in.release_lvl  = csr_data;
            REG_SEC_MODE:     cfg_in.sec_mode     = csr_data[MODE_W-1:0];
            REG_SEC_PRESS:    cfg_in.sec_press    = csr_data;
            REG_SEC_RELEASE:  cfg_in.sec_release  = csr_data;
            default:          cfg_in              = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: take samples, classify, queue
   akat_front #(
      .KEY_COUNT  (KEY_COUNT),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .accept_en (!stat.clearing),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .item_pop  (item_pop),
      .item_valid(item_valid),
      .item      (item)
   );

   // Back: update per-key state, queue results
   akat_back #(
      .KEY_COUNT(KEY_COUNT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .item_valid(item_valid),
      .item      (item),
      .item_pop  (item_pop),
      .stat      (stat),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   // Hold off intake while the state memory is being swept
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      stat.clearing |-> !req_tready)
      else $error("sample accepted during state clear");

   // An issued item lands in the result queue on the next cycle
   a_issue_lands: assert property (@(posedge clock) disable iff (reset)
      stat.issue |=> stat.result_push)
      else $error("issued item lost before the result queue");

   // Credit never exceeds the result queue depth
   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      stat.credit <= CRED_W'(RSP_DEPTH))
      else $error("result credit overrun");

   // A pending result is always covered by credit
   a_rsp_has_credit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (stat.credit != '0))
      else $error("result shown without credit");

endmodule
